FILE: sv/rsg_pkg.sv
// shared types, widths and helper functions of the rope spring gradient block
`default_nettype none
package rsg_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int PW   = 32;   // position field
	localparam int GW   = 35;   // signed stencil result
	localparam int MW   = 34;   // stencil magnitude, root, |d|
	localparam int SW   = 68;   // sum of squares
	localparam int KW   = 32;   // stiffness
	localparam int KDW  = 66;   // k * |d|
	localparam int PRW  = 100;  // multiplier product
	localparam int DENW = 50;   // divisor |g| << 16
	localparam int QW   = 47;   // quotient bits kept below saturation
	localparam int GRW  = 48;   // gradient
	localparam int VNW  = 10;   // vertex number

	localparam logic signed [GRW+2:0] POS_SAT = 51'sd140737488355327;
	localparam logic signed [GRW+2:0] NEG_SAT = -51'sd140737488355328;

	typedef struct packed {
		logic signed [PW-1:0] pos_x;
		logic signed [PW-1:0] pos_y;
		logic signed [PW-1:0] pos_z;
		logic signed [PW-1:0] rest_x;
		logic signed [PW-1:0] rest_y;
		logic signed [PW-1:0] rest_z;
		logic [KW-1:0]        element_stiffness;
		logic                 pinned;
		logic                 last_vertex;
	} in_t;

	typedef struct packed {
		logic signed [GRW-1:0] grad_x;
		logic signed [GRW-1:0] grad_y;
		logic signed [GRW-1:0] grad_z;
		logic [VNW-1:0]        vertex_number;
		logic                  vertex_pinned;
		logic                  end_of_rope;
	} out_t;

	function automatic logic [MW-1:0] mag(input logic signed [GW-1:0] v);
		logic signed [GW-1:0] a;
		a = v[GW-1] ? -v : v;
		return a[MW-1:0];
	endfunction

	function automatic logic signed [GRW-1:0] sat48(input logic signed [GRW+2:0] s);
		logic signed [GRW-1:0] r;
		if (s > POS_SAT) r = POS_SAT[GRW-1:0];
		else if (s < NEG_SAT) r = NEG_SAT[GRW-1:0];
		else r = s[GRW-1:0];
		return r;
	endfunction

	function automatic logic signed [GRW+2:0] ext51(input logic signed [GRW-1:0] v);
		return {{3{v[GRW-1]}}, v};
	endfunction

endpackage
`default_nettype wire

FILE: sv/rsg_mul.sv
// shift-add multiplier with accumulate input, one multiplier bit per cycle
`default_nettype none
module rsg_mul import rsg_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [KDW-1:0] a,
	input  wire logic [MW-1:0]  b,
	input  wire logic [PRW-1:0] acc,
	output logic                done,
	output logic [PRW-1:0]      p
);
	localparam int CW = $clog2(MW);

	logic           busy_q, done_q;
	logic [CW-1:0]  cnt_q;
	logic [PRW-1:0] a_q, p_q;
	logic [MW-1:0]  b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				a_q    <= PRW'(a);
				b_q    <= b;
				p_q    <= acc;
			end else if (busy_q) begin
				if (b_q[0]) p_q <= p_q + a_q;
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule
`default_nettype wire

FILE: sv/rsg_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none
module rsg_sqrt import rsg_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [SW-1:0] s,
	output logic               done,
	output logic [MW-1:0]      root
);
	localparam int CW = $clog2(MW);
	localparam int RW = MW + 3;

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] s_q;
	logic [RW-1:0] rem_q, remsh, trial;
	logic [MW-1:0] root_q;

	assign remsh = {rem_q[RW-3:0], s_q[SW-1:SW-2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			s_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				s_q    <= s;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				s_q <= s_q << 2;
				if (remsh >= trial) begin
					rem_q  <= remsh - trial;
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					rem_q  <= remsh;
					root_q <= {root_q[MW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

FILE: sv/rsg_div.sv
// restoring divider, one quotient bit per cycle, flags quotients past the gradient range
`default_nettype none
module rsg_div import rsg_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [PRW-1:0]  num,
	input  wire logic [DENW-1:0] den,
	output logic                 done,
	output logic [QW-1:0]        q,
	output logic                 over
);
	localparam int CW = $clog2(PRW);

	logic            busy_q, done_q, over_q;
	logic [CW-1:0]   cnt_q;
	logic [PRW-1:0]  n_q;
	logic [DENW-1:0] den_q;
	logic [DENW:0]   rem_q, remsh;
	logic [QW-1:0]   q_q;
	logic            bit_set;

	assign remsh   = {rem_q[DENW-1:0], n_q[PRW-1]};
	assign bit_set = remsh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			over_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				over_q <= 1'b0;
				cnt_q  <= '0;
				n_q    <= num;
				den_q  <= den;
				rem_q  <= '0;
				q_q    <= '0;
			end else if (busy_q) begin
				n_q   <= n_q << 1;
				rem_q <= bit_set ? remsh - {1'b0, den_q} : remsh;
				q_q   <= {q_q[QW-2:0], bit_set};
				if (bit_set && cnt_q < CW'(PRW - QW)) over_q <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(PRW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;
	assign over = over_q;
endmodule
`default_nettype wire

FILE: sv/rope_spring_gradient.sv
// top level: vertex sequencer, rope history, pending gradients and output register
`default_nettype none
// Vertices of a rope enter one at a time; each yields up to three gradient
// transactions. A vertex that closes an element needs six squarings and the
// k*|d| product on the shift-add multiplier, two square roots and, per axis,
// one product and one division, all on shared bit-serial units. in_ready is
// high only while the block is idle; results leave through an output register.
module rope_spring_gradient import rsg_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data,
	input  wire logic cfg_wen,
	input  wire logic cfg_wdata
);
	localparam int NW = $clog2(MAX_VERTICES);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_G = 4'd1, ST_SQ = 4'd2, ST_SQRT = 4'd3,
		ST_KD = 4'd4, ST_NUM = 4'd5, ST_DIV = 4'd6, ST_SCAT = 4'd7, ST_E0 = 4'd8,
		ST_E1 = 4'd9, ST_E2 = 4'd10, ST_COMMIT = 4'd11;

	logic [3:0]             state_q;
	logic                   bend_q;
	in_t                    in_q;
	logic                   last_q, elem_q, vec_q, dneg_q;
	logic [1:0]             comp_q, comp_nx;
	logic [NW-1:0]          nseen_q;
	logic signed [PW-1:0]   rec_p_q [2][3];
	logic signed [PW-1:0]   rec_r_q [2][3];
	logic signed [GRW-1:0]  pend_q  [3][3];
	logic                   pin_q   [3];
	logic signed [GW-1:0]   g_q [3], rg_q [3], gc [3], rgc [3];
	logic signed [PW-1:0]   cur_p [3], cur_r [3];
	logic [MW-1:0]          nrm_q;
	logic [KDW-1:0]         kd_q;
	logic signed [GRW-1:0]  f_q [3];
	logic                   out_valid_q;
	out_t                   out_q;

	logic                   mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
	logic [KDW-1:0]         mul_a;
	logic [MW-1:0]          mul_b;
	logic [PRW-1:0]         mul_acc, mul_p;
	logic [MW-1:0]          sqrt_root;
	logic [QW-1:0]          div_q;
	logic                   div_over;
	logic signed [MW:0]     d;
	logic [MW:0]            dabs;
	logic                   in_acc, out_free, is_last, fneg, emit_want;
	logic signed [GRW-1:0]  fval;
	logic [NW-1:0]          vn;
	logic [1:0]             eslot;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign comp_nx  = comp_q + 2'd1;
	assign is_last  = in_data.last_vertex || (nseen_q >= NW'(MAX_VERTICES - 1));

	// emit state that has a transaction to send
	assign emit_want = (state_q == ST_E0 && elem_q)
		|| (state_q == ST_E1 && bend_q && last_q && nseen_q != '0)
		|| (state_q == ST_E2 && last_q);

	assign cur_p[0] = in_q.pos_x;
	assign cur_p[1] = in_q.pos_y;
	assign cur_p[2] = in_q.pos_z;
	assign cur_r[0] = in_q.rest_x;
	assign cur_r[1] = in_q.rest_y;
	assign cur_r[2] = in_q.rest_z;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (bend_q) begin
				gc[c]  = GW'(rec_p_q[0][c]) - (GW'(rec_p_q[1][c]) <<< 1) + GW'(cur_p[c]);
				rgc[c] = GW'(rec_r_q[0][c]) - (GW'(rec_r_q[1][c]) <<< 1) + GW'(cur_r[c]);
			end else begin
				gc[c]  = GW'(cur_p[c]) - GW'(rec_p_q[1][c]);
				rgc[c] = GW'(cur_r[c]) - GW'(rec_r_q[1][c]);
			end
		end
	end

	assign d    = $signed({1'b0, nrm_q}) - $signed({1'b0, sqrt_root});
	assign dabs = d[MW] ? -d : d;

	assign fneg = dneg_q ^ g_q[comp_q][GW-1];
	always_comb begin
		if (fneg) fval = div_over ? NEG_SAT[GRW-1:0] : -$signed({1'b0, div_q});
		else      fval = div_over ? POS_SAT[GRW-1:0] : $signed({1'b0, div_q});
	end

	always_comb begin
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		mul_acc    = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_G: begin
				mul_start = 1'b1;
				mul_a     = KDW'(mag(gc[0]));
				mul_b     = mag(gc[0]);
			end
			ST_SQ: begin
				if (mul_done) begin
					if (comp_q != 2'd2) begin
						mul_start = 1'b1;
						mul_a     = KDW'(mag(vec_q ? rg_q[comp_nx] : g_q[comp_nx]));
						mul_b     = mag(vec_q ? rg_q[comp_nx] : g_q[comp_nx]);
						mul_acc   = mul_p;
					end else begin
						sqrt_start = 1'b1;
					end
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					mul_start = 1'b1;
					if (!vec_q) begin
						mul_a = KDW'(mag(rg_q[0]));
						mul_b = mag(rg_q[0]);
					end else begin
						mul_a = KDW'(dabs[MW-1:0]);
						mul_b = MW'(in_q.element_stiffness);
					end
				end
			end
			ST_KD: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_p[KDW-1:0];
					mul_b     = mag(g_q[0]);
				end
			end
			ST_NUM: begin
				div_start = mul_done;
			end
			ST_DIV: begin
				if (div_done && comp_q != 2'd2) begin
					mul_start = 1'b1;
					mul_a     = kd_q;
					mul_b     = mag(g_q[comp_nx]);
				end
			end
			default: begin
			end
		endcase
	end

	rsg_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.acc(mul_acc), .done(mul_done), .p(mul_p)
	);

	rsg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .s(mul_p[SW-1:0]),
		.done(sqrt_done), .root(sqrt_root)
	);

	rsg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mul_p),
		.den({nrm_q, 16'd0}), .done(div_done), .q(div_q), .over(div_over)
	);

	// which pending slot and vertex the current emit state reads
	always_comb begin
		unique case (state_q)
			ST_E0: begin
				eslot = bend_q ? 2'd0 : 2'd1;
				vn    = bend_q ? nseen_q - NW'(2) : nseen_q - NW'(1);
			end
			ST_E1: begin
				eslot = 2'd1;
				vn    = nseen_q - NW'(1);
			end
			default: begin
				eslot = 2'd2;
				vn    = nseen_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bend_q      <= 1'b0;
			nseen_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			in_q        <= '0;
			last_q      <= 1'b0;
			elem_q      <= 1'b0;
			vec_q       <= 1'b0;
			dneg_q      <= 1'b0;
			comp_q      <= '0;
			nrm_q       <= '0;
			kd_q        <= '0;
			for (int s = 0; s < 3; s++) begin
				pin_q[s] <= 1'b0;
				g_q[s]   <= '0;
				rg_q[s]  <= '0;
				f_q[s]   <= '0;
				for (int c = 0; c < 3; c++) pend_q[s][c] <= '0;
			end
			for (int s = 0; s < 2; s++) begin
				for (int c = 0; c < 3; c++) begin
					rec_p_q[s][c] <= '0;
					rec_r_q[s][c] <= '0;
				end
			end
		end else begin
			if (out_valid_q && out_ready && !(emit_want && out_free)) out_valid_q <= 1'b0;
			if (cfg_wen) begin
				bend_q  <= cfg_wdata;
				nseen_q <= '0;
				for (int s = 0; s < 3; s++) begin
					pin_q[s] <= 1'b0;
					for (int c = 0; c < 3; c++) pend_q[s][c] <= '0;
				end
				for (int s = 0; s < 2; s++) begin
					for (int c = 0; c < 3; c++) begin
						rec_p_q[s][c] <= '0;
						rec_r_q[s][c] <= '0;
					end
				end
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_acc) begin
						in_q     <= in_data;
						last_q   <= is_last;
						elem_q   <= bend_q ? (nseen_q >= NW'(2)) : (nseen_q != '0);
						pin_q[2] <= in_data.pinned;
						for (int c = 0; c < 3; c++) pend_q[2][c] <= '0;
						state_q  <= (bend_q ? (nseen_q >= NW'(2)) : (nseen_q != '0))
							? ST_G : ST_E0;
					end
				end
				ST_G: begin
					for (int c = 0; c < 3; c++) begin
						g_q[c]  <= gc[c];
						rg_q[c] <= rgc[c];
					end
					vec_q   <= 1'b0;
					comp_q  <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (mul_done) begin
						if (comp_q != 2'd2) comp_q <= comp_nx;
						else state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						comp_q <= '0;
						if (!vec_q) begin
							nrm_q   <= (sqrt_root == '0) ? MW'(1) : sqrt_root;
							vec_q   <= 1'b1;
							state_q <= ST_SQ;
						end else begin
							dneg_q  <= d[MW];
							state_q <= ST_KD;
						end
					end
				end
				ST_KD: begin
					if (mul_done) begin
						kd_q    <= mul_p[KDW-1:0];
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (mul_done) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						f_q[comp_q] <= fval;
						if (comp_q != 2'd2) begin
							comp_q  <= comp_nx;
							state_q <= ST_NUM;
						end else begin
							state_q <= ST_SCAT;
						end
					end
				end
				ST_SCAT: begin
					for (int c = 0; c < 3; c++) begin
						if (bend_q) begin
							pend_q[0][c] <= sat48(ext51(pend_q[0][c]) + ext51(f_q[c]));
							pend_q[1][c] <= sat48(ext51(pend_q[1][c]) - (ext51(f_q[c]) <<< 1));
						end else begin
							pend_q[1][c] <= sat48(ext51(pend_q[1][c]) - ext51(f_q[c]));
						end
						pend_q[2][c] <= sat48(ext51(pend_q[2][c]) + ext51(f_q[c]));
					end
					state_q <= ST_E0;
				end
				ST_E0, ST_E1, ST_E2: begin
					if (!emit_want) begin
						state_q <= (state_q == ST_E0) ? ST_E1
							: (state_q == ST_E1) ? ST_E2 : ST_COMMIT;
					end else if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.grad_x        <= pend_q[eslot][0];
						out_q.grad_y        <= pend_q[eslot][1];
						out_q.grad_z        <= pend_q[eslot][2];
						out_q.vertex_number <= VNW'(vn);
						out_q.vertex_pinned <= pin_q[eslot];
						out_q.end_of_rope   <= (state_q == ST_E2);
						state_q <= (state_q == ST_E0) ? ST_E1
							: (state_q == ST_E1) ? ST_E2 : ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (last_q) begin
						nseen_q <= '0;
						for (int s = 0; s < 3; s++) begin
							pin_q[s] <= 1'b0;
							for (int c = 0; c < 3; c++) pend_q[s][c] <= '0;
						end
						for (int s = 0; s < 2; s++) begin
							for (int c = 0; c < 3; c++) begin
								rec_p_q[s][c] <= '0;
								rec_r_q[s][c] <= '0;
							end
						end
					end else begin
						nseen_q  <= nseen_q + NW'(1);
						pin_q[0] <= pin_q[1];
						pin_q[1] <= pin_q[2];
						pin_q[2] <= 1'b0;
						for (int c = 0; c < 3; c++) begin
							rec_p_q[0][c] <= rec_p_q[1][c];
							rec_p_q[1][c] <= cur_p[c];
							rec_r_q[0][c] <= rec_r_q[1][c];
							rec_r_q[1][c] <= cur_r[c];
							pend_q[0][c]  <= pend_q[1][c];
							pend_q[1][c]  <= pend_q[2][c];
							pend_q[2][c]  <= '0;
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

FILE: test/rope_spring_gradient_test.sv
// testbench for rope_spring_gradient: directed table then random ropes, checked against a predictor
`default_nettype none
module rope_spring_gradient_test import rsg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXV = 1024;
	localparam int WATCHDOG = 20000;
	localparam longint GPOS = 64'sd140737488355327;
	localparam longint GNEG = -64'sd140737488355328;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;
	logic cfg_wen = 0;
	logic cfg_wdata = 0;

	rope_spring_gradient dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state
	bit bend;
	longint prev_pos[6];
	longint prev_rest[6];
	longint pend_grad[9];
	bit pend_pin[3];
	int next_vertex;

	out_t grad_queue[$];
	int errors = 0;
	int idle_count = 0;
	bit calm = 0;

	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= s) r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] vec_len(longint v[3]);
		logic [127:0] s;
		logic [63:0] m;
		s = 0;
		for (int c = 0; c < 3; c++) begin
			m = v[c] < 0 ? -v[c] : v[c];
			s += 128'(m) * 128'(m);
		end
		return isqrt(s);
	endfunction

	function automatic void spring_force(longint g[3], longint rg[3], logic [31:0] k,
			output longint f[3]);
		logic [63:0] nrm, rst, dm, gm;
		longint d;
		logic [255:0] num, q;
		bit neg;
		nrm = vec_len(g);
		rst = vec_len(rg);
		if (nrm == 0) nrm = 1;
		d = longint'(nrm) - longint'(rst);
		dm = d < 0 ? -d : d;
		for (int c = 0; c < 3; c++) begin
			gm = g[c] < 0 ? -g[c] : g[c];
			num = 256'(k) * 256'(dm) * 256'(gm);
			q = num / (256'(nrm) << 16);
			neg = (d < 0) != (g[c] < 0);
			if (q > 256'(GPOS)) f[c] = neg ? GNEG : GPOS;
			else f[c] = neg ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic void add_force(int slot, longint f[3], longint mult);
		longint s;
		for (int c = 0; c < 3; c++) begin
			s = pend_grad[slot*3+c] + mult * f[c];
			if (s > GPOS) s = GPOS;
			if (s < GNEG) s = GNEG;
			pend_grad[slot*3+c] = s;
		end
	endfunction

	function automatic void push_grad(int slot, int vn, bit eor);
		out_t o;
		o.grad_x = pend_grad[slot*3][47:0];
		o.grad_y = pend_grad[slot*3+1][47:0];
		o.grad_z = pend_grad[slot*3+2][47:0];
		o.vertex_number = vn[9:0];
		o.vertex_pinned = pend_pin[slot];
		o.end_of_rope = eor;
		grad_queue = {grad_queue, o};
	endfunction

	function automatic void clear_rope();
		foreach (prev_pos[i]) begin
			prev_pos[i] = 0;
			prev_rest[i] = 0;
		end
		foreach (pend_grad[i]) pend_grad[i] = 0;
		foreach (pend_pin[i]) pend_pin[i] = 0;
		next_vertex = 0;
	endfunction

	function automatic void predict_vertex(in_t v);
		int n;
		bit last;
		longint p[3], r[3], g[3], rg[3], f[3];
		n = next_vertex;
		last = v.last_vertex || n >= MAXV - 1;
		p[0] = v.pos_x; p[1] = v.pos_y; p[2] = v.pos_z;
		r[0] = v.rest_x; r[1] = v.rest_y; r[2] = v.rest_z;
		for (int c = 0; c < 3; c++) pend_grad[6+c] = 0;
		pend_pin[2] = v.pinned;
		if (!bend) begin
			if (n >= 1) begin
				for (int c = 0; c < 3; c++) begin
					g[c] = p[c] - prev_pos[3+c];
					rg[c] = r[c] - prev_rest[3+c];
				end
				spring_force(g, rg, v.element_stiffness, f);
				add_force(1, f, -1);
				add_force(2, f, 1);
				push_grad(1, n - 1, 0);
			end
		end else begin
			if (n >= 2) begin
				for (int c = 0; c < 3; c++) begin
					g[c] = prev_pos[c] - 2 * prev_pos[3+c] + p[c];
					rg[c] = prev_rest[c] - 2 * prev_rest[3+c] + r[c];
				end
				spring_force(g, rg, v.element_stiffness, f);
				add_force(0, f, 1);
				add_force(1, f, -2);
				add_force(2, f, 1);
				push_grad(0, n - 2, 0);
			end
			if (last && n >= 1) push_grad(1, n - 1, 0);
		end
		if (last) begin
			push_grad(2, n, 1);
			clear_rope();
			return;
		end
		for (int c = 0; c < 3; c++) begin
			prev_pos[c] = prev_pos[3+c];
			prev_pos[3+c] = p[c];
			prev_rest[c] = prev_rest[3+c];
			prev_rest[3+c] = r[c];
			pend_grad[c] = pend_grad[3+c];
			pend_grad[3+c] = pend_grad[6+c];
			pend_grad[6+c] = 0;
		end
		pend_pin[0] = pend_pin[1];
		pend_pin[1] = pend_pin[2];
		pend_pin[2] = 0;
		next_vertex = n + 1;
	endfunction

	// output side: random stalls, compare each transaction
	always @(negedge clk) begin
		if (arst_n) out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (grad_queue.size() == 0) begin
				$display("%0t unexpected gradient %p", $time, out_data);
				errors++;
			end else begin
				e = grad_queue.pop_front();
				if (out_data !== e) begin
					$display("%0t mismatch expected %p actual %p", $time, e, out_data);
					errors++;
				end
			end
		end
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready))) idle_count++;
		else idle_count = 0;
		if (idle_count >= WATCHDOG) begin
			$display("rope_spring_gradient_test NOT OK");
			$finish;
		end
	end

	task automatic send_vertex(in_t v);
		while ($urandom_range(0, 99) < 30 && !calm) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_vertex(v);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (grad_queue.size() != 0) @(negedge clk);
		repeat (800) @(negedge clk);
	endtask

	task automatic set_mode(bit m);
		drain();
		cfg_wen <= 1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_wen <= 0;
		bend = m;
		clear_rope();
	endtask

	function automatic in_t mk(int px, int py, int pz, int rx, int ry, int rz,
			logic [31:0] k, bit pin, bit last);
		in_t v;
		v.pos_x = px; v.pos_y = py; v.pos_z = pz;
		v.rest_x = rx; v.rest_y = ry; v.rest_z = rz;
		v.element_stiffness = k; v.pinned = pin; v.last_vertex = last;
		return v;
	endfunction

	function automatic int rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return int'($urandom_range(0, 20 << 16)) - (10 << 16);
		endcase
	endfunction

	function automatic in_t rnd_vertex(bit last);
		logic [31:0] k;
		k = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000);
		return mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord(), k, $urandom_range(0, 1), last);
	endfunction

	in_t directed[$];
	in_t bend_rows[$];
	int len;

	initial begin
		bend = 0;
		clear_rope();
		repeat (2) @(negedge clk);
		arst_n = 1;
		// single vertex rope, then extremes
		directed = {
			mk(0, 0, 0, 0, 0, 0, 0, 1, 1),
			mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0, 0),
			mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 32'hffffffff, 1, 0),
			mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 32'hffffffff, 0, 0),
			mk(1 << 16, 0, 0, 1 << 16, 0, 0, 1 << 16, 1, 1),
			mk(0, 0, 0, 0, 0, 0, 1 << 16, 0, 0),
			mk(0, 3 << 16, 0, 0, 1 << 16, 0, 2 << 16, 0, 1)
		};
		foreach (directed[i]) send_vertex(directed[i]);
		// bending: single vertex rope, short rope, extremes
		bend_rows = {
			mk(5, 5, 5, 0, 0, 0, 7, 1, 1),
			mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
			mk(1 << 16, 0, 0, 0, 0, 0, 1, 0, 1),
			mk(0, 0, 0, 0, 0, 0, 0, 1, 0),
			mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0, 0),
			mk(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1, 32'hffffffff, 1, 0),
			mk(32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 32'hffffffff, 0, 1)
		};
		set_mode(1);
		foreach (bend_rows[i]) send_vertex(bend_rows[i]);
		// rope cut short by a mode write
		send_vertex(rnd_vertex(0));
		send_vertex(rnd_vertex(0));
		set_mode(0);
		// random ropes, with a calm stretch in the middle
		for (int r = 0; r < 40; r++) begin
			calm = (r >= 15 && r < 22);
			if (r == 20) set_mode(1);
			if (r == 30) set_mode(0);
			if (r == 35) set_mode(1);
			len = $urandom_range(1, 7);
			for (int i = 0; i < len; i++) send_vertex(rnd_vertex(i == len - 1));
		end
		calm = 0;
		drain();
		if (errors == 0) $display("rope_spring_gradient_test OK");
		else $display("rope_spring_gradient_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

FILE: rope_spring_gradient.f
sv/rsg_pkg.sv
sv/rsg_mul.sv
sv/rsg_sqrt.sv
sv/rsg_div.sv
sv/rope_spring_gradient.sv
test/rope_spring_gradient_test.sv
